// ===== hw/rtl/e2r_pkg.sv =====
package e2r_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_BITS = FRAC_BITS + 2;
    localparam int TRIG_BITS = 33;
    localparam int STEPS = 30;
    localparam int PROD_BITS = 2 * TRIG_BITS;
    localparam int OUT_SHIFT = 30 - FRAC_BITS;
    localparam int NUM_LANES = 3;
    localparam int NUM_ENTRIES = 9;
    localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] SEQ_XYX = 2'd0;
    localparam logic [1:0] SEQ_XYZ = 2'd1;
    localparam logic [1:0] SEQ_XZX = 2'd2;

    typedef logic signed [ANGLE_BITS-1:0] t_angle;
    typedef logic signed [OUT_BITS-1:0] t_entry;
    typedef logic signed [TRIG_BITS-1:0] t_trig;

    typedef struct packed {
        t_angle angle_a;
        t_angle angle_b;
        t_angle angle_c;
    } t_in_item;

    typedef struct packed {
        t_entry r00;
        t_entry r01;
        t_entry r02;
        t_entry r10;
        t_entry r11;
        t_entry r12;
        t_entry r20;
        t_entry r21;
        t_entry r22;
    } t_out_item;

    function automatic logic signed [33:0] atan_step(input int i);
        case (i)
            0: atan_step = 34'sd536870912;
            1: atan_step = 34'sd316933406;
            2: atan_step = 34'sd167458907;
            3: atan_step = 34'sd85004756;
            4: atan_step = 34'sd42667331;
            5: atan_step = 34'sd21354465;
            6: atan_step = 34'sd10679838;
            7: atan_step = 34'sd5340245;
            8: atan_step = 34'sd2670163;
            9: atan_step = 34'sd1335087;
            10: atan_step = 34'sd667544;
            11: atan_step = 34'sd333772;
            12: atan_step = 34'sd166886;
            13: atan_step = 34'sd83443;
            14: atan_step = 34'sd41722;
            15: atan_step = 34'sd20861;
            16: atan_step = 34'sd10430;
            17: atan_step = 34'sd5215;
            18: atan_step = 34'sd2608;
            19: atan_step = 34'sd1304;
            20: atan_step = 34'sd652;
            21: atan_step = 34'sd326;
            22: atan_step = 34'sd163;
            23: atan_step = 34'sd81;
            24: atan_step = 34'sd41;
            25: atan_step = 34'sd20;
            26: atan_step = 34'sd10;
            27: atan_step = 34'sd5;
            28: atan_step = 34'sd3;
            29: atan_step = 34'sd1;
            default: atan_step = 34'sd0;
        endcase
    endfunction

    // q2.30 product with round half up
    function automatic t_trig mul_q30(input t_trig a, input t_trig b);
        logic signed [PROD_BITS-1:0] p;
        begin
            p = PROD_BITS'(a) * PROD_BITS'(b) + (PROD_BITS'(1) <<< 29);
            mul_q30 = TRIG_BITS'(p >>> 30);
        end
    endfunction

    function automatic t_entry to_entry(input logic signed [TRIG_BITS+1:0] v);
        logic signed [TRIG_BITS+1:0] r;
        logic signed [TRIG_BITS+1:0] lim;
        begin
            lim = (TRIG_BITS+2)'(1) <<< FRAC_BITS;
            if (OUT_SHIFT == 0) begin
                r = v;
            end else begin
                r = (v + ((TRIG_BITS+2)'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            end
            if (r > lim) begin
                r = lim;
            end
            if (r < -lim) begin
                r = -lim;
            end
            to_entry = OUT_BITS'(r);
        end
    endfunction

endpackage

// ===== hw/rtl/e2r_if.sv =====
interface e2r_in_if;
    import e2r_pkg::*;
    logic valid;
    logic ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface e2r_out_if;
    import e2r_pkg::*;
    logic valid;
    logic ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// channel   | dir | payload
// in_ch     | in  | angle_a, angle_b, angle_c (s16 binary angle)
// out_ch    | out | r00..r22 (s16 q1.14)
// cfg       | in  | axis_sequence (2 bits, values above 2 ignored)
// one item per cycle while the output is not stalled; pipeline: 31 cordic steps in three lanes,
// two product stages, one output register
// the whole pipeline advances only when the output register is free or taken
// synchronous active-low reset clears valid bits and the sequence register
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    e2r_in_if.sink     in_ch,
    e2r_out_if.source  out_ch,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    localparam int LAT = STEPS + 4;

    logic [1:0]     r_seq;
    logic [LAT-1:0] r_vld;
    logic           en;
    t_trig          s [NUM_LANES];
    t_trig          c [NUM_LANES];
    t_angle         ang [NUM_LANES];

    assign en = !r_vld[LAT-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_XYX;
            r_vld <= '0;
        end else begin
            if (i_cfg_we && i_cfg_data <= SEQ_XZX) begin
                r_seq <= i_cfg_data;
            end
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], in_ch.valid};
            end
        end
    end

    assign ang[0] = in_ch.data.angle_a;
    assign ang[1] = in_ch.data.angle_b;
    assign ang[2] = in_ch.data.angle_c;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        e2r_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (ang[l]),
            .o_sin   (s[l]),
            .o_cos   (c[l])
        );
    end

    e2r_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_seq  (r_seq),
        .i_sa   (s[0]),
        .i_ca   (c[0]),
        .i_sb   (s[1]),
        .i_cb   (c[1]),
        .i_sc   (s[2]),
        .i_cc   (c[2]),
        .o_item (out_ch.data)
    );

endmodule

// ===== hw/rtl/e2r_cordic.sv =====
module e2r_cordic
    import e2r_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_angle i_angle,
    output t_trig  o_sin,
    output t_trig  o_cos
);

    logic signed [TRIG_BITS:0] r_x [STEPS+1];
    logic signed [TRIG_BITS:0] r_y [STEPS+1];
    logic signed [33:0]        r_z [STEPS+1];
    logic [1:0]                r_k [STEPS+1];

    logic [31:0] th;
    logic [1:0]  k0;
    logic [31:0] d0;

    assign th = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign k0 = 2'((th + 32'h2000_0000) >> 30);
    assign d0 = th - {k0, 30'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= (TRIG_BITS+1)'(CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= 34'(signed'(d0));
            r_k[0] <= k0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_step(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_step(i);
                end
                r_k[i+1] <= r_k[i];
            end
        end
    end

    t_trig x;
    t_trig y;
    assign x = TRIG_BITS'(r_x[STEPS]);
    assign y = TRIG_BITS'(r_y[STEPS]);

    always_comb begin
        case (r_k[STEPS])
            2'd0: begin o_cos = x;  o_sin = y;  end
            2'd1: begin o_cos = -y; o_sin = x;  end
            2'd2: begin o_cos = -x; o_sin = -y; end
            default: begin o_cos = y; o_sin = -x; end
        endcase
    end

endmodule

// ===== hw/rtl/e2r_merge.sv =====
module e2r_merge
    import e2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  logic [1:0] i_seq,
    input  t_trig     i_sa,
    input  t_trig     i_ca,
    input  t_trig     i_sb,
    input  t_trig     i_cb,
    input  t_trig     i_sc,
    input  t_trig     i_cc,
    output t_out_item o_item
);

    // stage 1: pair products
    t_trig r_sacb, r_cacb, r_sasb, r_casb, r_sasc, r_sacc, r_casc, r_cacc;
    t_trig r_cbcc, r_cbsc, r_sbcc, r_sbsc, r_cb, r_sb, r_sc1, r_cc1;
    logic [1:0] r_seq1;
    // stage 2: triple products
    t_trig r_t1, r_t2, r_t3, r_t4;
    t_trig r_sasc2, r_sacc2, r_casc2, r_cacc2, r_sasb2, r_casb2, r_sacb2, r_cacb2;
    t_trig r_cbcc2, r_cbsc2, r_sbcc2, r_sbsc2, r_cb2, r_sb2;
    logic [1:0] r_seq2;
    logic signed [TRIG_BITS+1:0] m [NUM_ENTRIES];
    t_out_item n_item;
    t_out_item r_item;

    function automatic logic signed [TRIG_BITS+1:0] ext(input t_trig v);
        ext = (TRIG_BITS+2)'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sacb <= mul_q30(i_sa, i_cb);
            r_cacb <= mul_q30(i_ca, i_cb);
            r_sasb <= mul_q30(i_sa, i_sb);
            r_casb <= mul_q30(i_ca, i_sb);
            r_sasc <= mul_q30(i_sa, i_sc);
            r_sacc <= mul_q30(i_sa, i_cc);
            r_casc <= mul_q30(i_ca, i_sc);
            r_cacc <= mul_q30(i_ca, i_cc);
            r_cbcc <= mul_q30(i_cb, i_cc);
            r_cbsc <= mul_q30(i_cb, i_sc);
            r_sbcc <= mul_q30(i_sb, i_cc);
            r_sbsc <= mul_q30(i_sb, i_sc);
            r_cb <= i_cb;
            r_sb <= i_sb;
            // c-angle values delayed one stage to line up with pair products
            r_sc1 <= i_sc;
            r_cc1 <= i_cc;
            r_seq1 <= i_seq;

            if (r_seq1 == SEQ_XYZ) begin
                r_t1 <= mul_q30(r_sasb, r_cc1);
                r_t2 <= mul_q30(r_sasb, r_sc1);
                r_t3 <= mul_q30(r_casb, r_cc1);
                r_t4 <= mul_q30(r_casb, r_sc1);
            end else begin
                r_t1 <= mul_q30(r_sacb, r_cc1);
                r_t2 <= mul_q30(r_sacb, r_sc1);
                r_t3 <= mul_q30(r_cacb, r_cc1);
                r_t4 <= mul_q30(r_cacb, r_sc1);
            end
            r_sasc2 <= r_sasc; r_sacc2 <= r_sacc; r_casc2 <= r_casc; r_cacc2 <= r_cacc;
            r_sasb2 <= r_sasb; r_casb2 <= r_casb; r_sacb2 <= r_sacb; r_cacb2 <= r_cacb;
            r_cbcc2 <= r_cbcc; r_cbsc2 <= r_cbsc; r_sbcc2 <= r_sbcc; r_sbsc2 <= r_sbsc;
            r_cb2 <= r_cb; r_sb2 <= r_sb;
            r_seq2 <= r_seq1;

            r_item <= n_item;
        end
    end

    always_comb begin
        case (r_seq2)
            SEQ_XYZ: begin
                m[0] = ext(r_cbcc2);
                m[1] = -ext(r_cbsc2);
                m[2] = ext(r_sb2);
                m[3] = ext(r_t1) + ext(r_casc2);
                m[4] = -ext(r_t2) + ext(r_cacc2);
                m[5] = -ext(r_sacb2);
                m[6] = -ext(r_t3) + ext(r_sasc2);
                m[7] = ext(r_t4) + ext(r_sacc2);
                m[8] = ext(r_cacb2);
            end
            SEQ_XZX: begin
                m[0] = ext(r_cb2);
                m[1] = -ext(r_sbcc2);
                m[2] = ext(r_sbsc2);
                m[3] = ext(r_casb2);
                m[4] = ext(r_t3) - ext(r_sasc2);
                m[5] = -ext(r_t4) - ext(r_sacc2);
                m[6] = ext(r_sasb2);
                m[7] = ext(r_t1) + ext(r_casc2);
                m[8] = -ext(r_t2) + ext(r_cacc2);
            end
            default: begin
                m[0] = ext(r_cb2);
                m[1] = ext(r_sbsc2);
                m[2] = ext(r_sbcc2);
                m[3] = ext(r_sasb2);
                m[4] = -ext(r_t2) + ext(r_cacc2);
                m[5] = -ext(r_t1) - ext(r_casc2);
                m[6] = -ext(r_casb2);
                m[7] = ext(r_t4) + ext(r_sacc2);
                m[8] = ext(r_t3) - ext(r_sasc2);
            end
        endcase
    end

    always_comb begin
        n_item.r00 = to_entry(m[0]);
        n_item.r01 = to_entry(m[1]);
        n_item.r02 = to_entry(m[2]);
        n_item.r10 = to_entry(m[3]);
        n_item.r11 = to_entry(m[4]);
        n_item.r12 = to_entry(m[5]);
        n_item.r20 = to_entry(m[6]);
        n_item.r21 = to_entry(m[7]);
        n_item.r22 = to_entry(m[8]);
    end

    assign o_item = r_item;

endmodule

// ===== sim/tb_pkg.sv =====
`timescale 1ns / 100ps

package tb_pkg;
    import e2r_pkg::*;

    typedef logic signed [63:0] q30_t;

    localparam logic signed [63:0] ATAN_TURNS [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1
    };

    function automatic q30_t qmul(input q30_t a, input q30_t b);
        q30_t p;
        begin
            p = a * b + (64'sd1 <<< 29);
            qmul = p >>> 30;
        end
    endfunction

    function automatic void trig_of(input t_angle ang, output q30_t s, output q30_t c);
        logic [31:0] th;
        logic [1:0] quad;
        logic [31:0] d;
        q30_t z, x, y, dx, dy;
        begin
            th = {ang, 16'h0};
            quad = 2'((th + 32'h2000_0000) >> 30);
            d = th - ({30'h0, quad} << 30);
            z = q30_t'($signed(d));
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
                end
            end
            case (quad)
                2'd0: begin c = x; s = y; end
                2'd1: begin c = -y; s = x; end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        end
    endfunction

    function automatic t_entry q30_to_entry(input q30_t v);
        q30_t r;
        begin
            r = (v + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            if (r > (64'sd1 <<< FRAC_BITS)) r = 64'sd1 <<< FRAC_BITS;
            if (r < -(64'sd1 <<< FRAC_BITS)) r = -(64'sd1 <<< FRAC_BITS);
            q30_to_entry = t_entry'(r);
        end
    endfunction

    function automatic t_out_item rotation_of(input t_in_item it, input logic [1:0] seq);
        q30_t sa, ca, sb, cb, sc, cc;
        q30_t m [9];
        t_out_item o;
        begin
            trig_of(it.angle_a, sa, ca);
            trig_of(it.angle_b, sb, cb);
            trig_of(it.angle_c, sc, cc);
            if (seq == SEQ_XYZ) begin
                m[0] = qmul(cb, cc);
                m[1] = -qmul(cb, sc);
                m[2] = sb;
                m[3] = qmul(qmul(sa, sb), cc) + qmul(ca, sc);
                m[4] = -qmul(qmul(sa, sb), sc) + qmul(ca, cc);
                m[5] = -qmul(sa, cb);
                m[6] = -qmul(qmul(ca, sb), cc) + qmul(sa, sc);
                m[7] = qmul(qmul(ca, sb), sc) + qmul(sa, cc);
                m[8] = qmul(ca, cb);
            end else if (seq == SEQ_XZX) begin
                m[0] = cb;
                m[1] = -qmul(sb, cc);
                m[2] = qmul(sb, sc);
                m[3] = qmul(ca, sb);
                m[4] = qmul(qmul(ca, cb), cc) - qmul(sa, sc);
                m[5] = -qmul(qmul(ca, cb), sc) - qmul(sa, cc);
                m[6] = qmul(sa, sb);
                m[7] = qmul(qmul(sa, cb), cc) + qmul(ca, sc);
                m[8] = -qmul(qmul(sa, cb), sc) + qmul(ca, cc);
            end else begin
                m[0] = cb;
                m[1] = qmul(sb, sc);
                m[2] = qmul(sb, cc);
                m[3] = qmul(sa, sb);
                m[4] = -qmul(qmul(sa, cb), sc) + qmul(ca, cc);
                m[5] = -qmul(qmul(sa, cb), cc) - qmul(ca, sc);
                m[6] = -qmul(ca, sb);
                m[7] = qmul(qmul(ca, cb), sc) + qmul(sa, cc);
                m[8] = qmul(qmul(ca, cb), cc) - qmul(sa, sc);
            end
            o.r00 = q30_to_entry(m[0]); o.r01 = q30_to_entry(m[1]);
            o.r02 = q30_to_entry(m[2]); o.r10 = q30_to_entry(m[3]);
            o.r11 = q30_to_entry(m[4]); o.r12 = q30_to_entry(m[5]);
            o.r20 = q30_to_entry(m[6]); o.r21 = q30_to_entry(m[7]);
            o.r22 = q30_to_entry(m[8]);
            rotation_of = o;
        end
    endfunction
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import e2r_pkg::*;
    import tb_pkg::*;

    localparam int LATENCY = 34;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = '0;

    e2r_in_if in_ch ();
    e2r_out_if out_ch ();

    euler_to_rotation_matrix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_item pending_angles [$];
    t_out_item expected_matrices [$];
    logic [1:0] seq_reg = SEQ_XYX;
    int mismatches = 0;
    int cycles = 0;
    int send_gap = 0;
    int take_gap = 0;
    bit quiet_phase = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (quiet_phase || r < 60) gap_len = 0;
            else if (r < 93) gap_len = $urandom_range(1, 3);
            else gap_len = $urandom_range(4, 40);
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (in_ch.valid && in_ch.ready) begin
            expected_matrices.push_back(rotation_of(in_ch.data, seq_reg));
        end
        if (!in_ch.valid || in_ch.ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_angles.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_angles.pop_front();
                send_gap <= gap_len();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_matrices.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected transfer %h", got);
            end else begin
                want = expected_matrices.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("mismatch exp %h got %h", want, got);
                end
            end
        end
        if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            take_gap <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[euler_to_rotation_matrix] ERROR");
            $finish;
        end
    end

    function automatic t_angle rand_angle();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0) rand_angle = t_angle'({$urandom_range(0, 3), 14'h0});
            else if (r == 1) rand_angle = t_angle'({$urandom_range(0, 3), 14'h0}
                + $urandom_range(0, 6) - 3);
            else rand_angle = t_angle'($urandom());
        end
    endfunction

    task automatic drain();
        begin
            while (pending_angles.size() > 0 || in_ch.valid || expected_matrices.size() > 0)
                @(posedge i_clk);
            repeat (LATENCY + 4) @(posedge i_clk);
        end
    endtask

    task automatic set_seq(input logic [1:0] v);
        begin
            i_cfg_we <= 1'b1;
            i_cfg_data <= v;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            if (v <= SEQ_XZX) seq_reg = v;
        end
    endtask

    localparam logic [1:0] SEQ_BAD = 2'd3;

    initial begin
        t_in_item it;
        t_angle edges [8];
        logic [1:0] seqs [6];
        edges = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh4000, 16'shc000, 16'sh0001,
                  16'shffff, 16'sh2000};
        seqs = '{SEQ_XYZ, SEQ_XZX, SEQ_BAD, SEQ_XYX, SEQ_XZX, SEQ_XYZ};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < 7; s++) begin
            if (s > 0) begin
                drain();
                set_seq(seqs[s - 1]);
            end
            if (s < 3) begin
                for (int j = 0; j < 8; j++) begin
                    it.angle_a = edges[j];
                    it.angle_b = edges[(j + 3) % 8];
                    it.angle_c = edges[(j + 5) % 8];
                    pending_angles.push_back(it);
                end
            end
            quiet_phase = (s == 4);
            for (int j = 0; j < 250; j++) begin
                it.angle_a = rand_angle();
                it.angle_b = rand_angle();
                it.angle_c = rand_angle();
                pending_angles.push_back(it);
                if (j == 125) begin
                    while (pending_angles.size() > 0 || in_ch.valid) @(posedge i_clk);
                    send_gap = 2;
                    while (expected_matrices.size() > 0) @(posedge i_clk);
                end
            end
        end
        drain();
        if (mismatches == 0) begin
            $display("[euler_to_rotation_matrix] OK");
        end else begin
            $display("[euler_to_rotation_matrix] ERROR");
        end
        $finish;
    end
endmodule
